// ===== src/olist_pkg.sv =====
package olist_pkg;

   localparam int VAL_W            = 32;
   localparam int CNT_W            = 8;
   localparam int IDX_OUT_W        = 7;
   localparam int DEFAULT_CAPACITY = 128;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_BAD_POS = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_CAPTURE = 2'd1,
      OP_INSERT  = 2'd2,
      OP_REMOVE  = 2'd3
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAPTURE,
      ST_GROUP,
      ST_SELECT,
      ST_APPLY
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cell_op_type             op;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        sel;
      logic [CNT_W-1:0]        cnt;
   } cell_cmd_type;

endpackage

// ===== src/olist_if.sv =====
interface olist_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           req_type;
   logic signed [olist_pkg::VAL_W-1:0]   item_value;
   logic [olist_pkg::CNT_W-1:0]          position;

   modport source (output valid, output req_type, output item_value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input item_value, input position,
                   output ready);
endinterface

interface olist_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [olist_pkg::IDX_OUT_W-1:0]    found_index;
   logic [olist_pkg::CNT_W-1:0]        entry_count;

   modport source (output valid, output status, output found_index, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_index, input entry_count,
                   output ready);
endinterface

// ===== src/olist_cell.sv =====
module olist_cell #(
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  olist_pkg::cell_cmd_type             cmd,
   input  logic signed [olist_pkg::VAL_W-1:0]  lower_entry,
   input  logic signed [olist_pkg::VAL_W-1:0]  upper_entry,
   output logic signed [olist_pkg::VAL_W-1:0]  entry,
   output logic                                match
);

   localparam logic [olist_pkg::CNT_W-1:0] IDX = olist_pkg::CNT_W'(INDEX);

   logic signed [olist_pkg::VAL_W-1:0] entry_ff, entry_in;
   logic                               match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      case (cmd.op)
         olist_pkg::OP_CAPTURE: begin
            match_in = (entry_ff == cmd.value) && (IDX < cmd.cnt);
         end
         olist_pkg::OP_INSERT: begin
            if (IDX == cmd.sel) begin
               entry_in = cmd.value;
            end else if (IDX > cmd.sel && IDX <= cmd.cnt) begin
               entry_in = lower_entry;
            end
         end
         olist_pkg::OP_REMOVE: begin
            // pull from the upper neighbor from the match up to the cell below the old tail
            if (IDX >= cmd.sel && ({1'b0, IDX} + 9'd1) < {1'b0, cmd.cnt}) begin
               entry_in = upper_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== src/olist_match_enc.sv =====
module olist_match_enc #(
   parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic [CAPACITY-1:0]            match_vec,
   output logic                           hit,
   output logic [olist_pkg::CNT_W-1:0]    hit_index
);

   localparam int GRP_SIZE = 8;
   localparam int GRP_W    = 3;
   localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   logic [NGRP*GRP_SIZE-1:0] padded;
   logic [NGRP-1:0]          grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]         grp_idx_ff [NGRP];
   logic [GRP_W-1:0]         grp_idx_in [NGRP];
   logic                     hit_ff, hit_in;
   logic [olist_pkg::CNT_W-1:0] idx_ff, idx_in;

   assign padded = (NGRP*GRP_SIZE)'(match_vec);

   // first stage: lowest set bit within each group of eight
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |padded[g*GRP_SIZE +: GRP_SIZE];
         grp_idx_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (padded[g*GRP_SIZE + b]) begin
               grp_idx_in[g] = GRP_W'(b);
            end
         end
      end
   end

   // second stage: lowest group that has a hit
   always_comb begin
      hit_in = |grp_any_ff;
      idx_in = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            idx_in = (olist_pkg::CNT_W'(g) << GRP_W) | olist_pkg::CNT_W'(grp_idx_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
      hit_ff     <= hit_in;
      idx_ff     <= idx_in;
   end

   assign hit       = hit_ff;
   assign hit_index = idx_ff;

endmodule

// ===== src/ordered_list_insert_find_remove_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one value per cell in list order. A transaction on req inserts item_value at
// position, finds the first entry equal to item_value, or removes the first
// such entry; each one returns exactly one rsp transaction with status,
// found_index and the entry count after the request. One request is handled
// at a time. Insert and the unused request code go from acceptance straight to
// the apply state, which loads the response register; find and remove first
// pass the capture, group and select states, which cover the cell compare
// register and the two-stage registered priority encoder that picks the first
// match. The apply state waits for room in rsp; the next request is accepted
// in the cycle after the response is loaded. Reset clears the count, state and
// rsp valid but not the entries; no cell at or above the count is ever reported.
module ordered_list_insert_find_remove_unit #(
   parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   olist_req_if.sink    req,
   olist_rsp_if.source  rsp
);

   localparam logic [olist_pkg::CNT_W-1:0] CAP_CNT = olist_pkg::CNT_W'(CAPACITY);

   olist_pkg::state_type     state_ff, state_in;
   olist_pkg::cell_cmd_type  cmd;

   logic [1:0]                          kind_ff, kind_in;
   logic signed [olist_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [olist_pkg::CNT_W-1:0]         pos_ff, pos_in;
   logic [olist_pkg::CNT_W-1:0]         count_ff, count_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic [olist_pkg::IDX_OUT_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [olist_pkg::CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic signed [olist_pkg::VAL_W-1:0]  entry_q [CAPACITY];
   logic [CAPACITY-1:0]                 match_vec;
   logic                                hit;
   logic [olist_pkg::CNT_W-1:0]         hit_index;
   logic                                slot_free;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [olist_pkg::VAL_W-1:0] lower, upper;
         if (i > 0) begin : g_lo
            assign lower = entry_q[i-1];
         end else begin : g_lo0
            assign lower = '0;
         end
         if (i < CAPACITY - 1) begin : g_up
            assign upper = entry_q[i+1];
         end else begin : g_up_last
            assign upper = '0;
         end
         olist_cell #(
            .INDEX (i)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .lower_entry (lower),
            .upper_entry (upper),
            .entry       (entry_q[i]),
            .match       (match_vec[i])
         );
      end
   endgenerate

   olist_match_enc #(
      .CAPACITY (CAPACITY)
   ) u_match_enc (
      .clock     (clock),
      .match_vec (match_vec),
      .hit       (hit),
      .hit_index (hit_index)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == olist_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      cmd.op        = olist_pkg::OP_HOLD;
      cmd.value     = value_ff;
      cmd.sel       = pos_ff;
      cmd.cnt       = count_ff;

      case (state_ff)
         olist_pkg::ST_IDLE: begin
            if (req.valid) begin
               kind_in  = req.req_type;
               value_in = req.item_value;
               pos_in   = req.position;
               if (req.req_type == olist_pkg::KIND_FIND
                   || req.req_type == olist_pkg::KIND_REMOVE) begin
                  state_in = olist_pkg::ST_CAPTURE;
               end else begin
                  state_in = olist_pkg::ST_APPLY;
               end
            end
         end
         olist_pkg::ST_CAPTURE: begin
            cmd.op   = olist_pkg::OP_CAPTURE;
            state_in = olist_pkg::ST_GROUP;
         end
         olist_pkg::ST_GROUP: begin
            state_in = olist_pkg::ST_SELECT;
         end
         olist_pkg::ST_SELECT: begin
            state_in = olist_pkg::ST_APPLY;
         end
         olist_pkg::ST_APPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = olist_pkg::STATUS_OK;
               rsp_index_in  = '0;
               rsp_count_in  = count_ff;
               state_in      = olist_pkg::ST_IDLE;
               case (kind_ff)
                  olist_pkg::KIND_INSERT: begin
                     if (count_ff >= CAP_CNT) begin
                        rsp_status_in = olist_pkg::STATUS_FULL;
                     end else if (pos_ff > count_ff) begin
                        rsp_status_in = olist_pkg::STATUS_BAD_POS;
                     end else begin
                        cmd.op       = olist_pkg::OP_INSERT;
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = count_ff + 1'b1;
                     end
                  end
                  olist_pkg::KIND_FIND, olist_pkg::KIND_REMOVE: begin
                     if (!hit) begin
                        rsp_status_in = olist_pkg::STATUS_MISSING;
                     end else begin
                        rsp_index_in = hit_index[olist_pkg::IDX_OUT_W-1:0];
                        if (kind_ff == olist_pkg::KIND_REMOVE) begin
                           cmd.op       = olist_pkg::OP_REMOVE;
                           cmd.sel      = hit_index;
                           count_in     = count_ff - 1'b1;
                           rsp_count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = olist_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_index = rsp_index_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule
